// File: hdl/rleid_pkg.sv
`default_nettype none

package rleid_pkg;

   localparam int unsigned BYTE_WIDTH       = 8;
   localparam int unsigned SIZE_WIDTH       = 16;
   localparam int unsigned PIXEL_WIDTH      = 32;
   localparam int unsigned CSR_INDEX_WIDTH  = 2;

   localparam int unsigned PKT_TYPE_BIT     = 7;
   localparam logic [6:0]  PKT_COUNT_MASK   = 7'h7F;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW_COUNT  = 2'd1;

   localparam int unsigned SETTLE_WIDTH     = 2;
   localparam logic [SETTLE_WIDTH-1:0] SETTLE_CYCLES = 2'd2;

   localparam int unsigned QUEUE_DEPTH       = 2;
   localparam int unsigned QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_BLUE   = 4'b0010,
      PH_GREEN  = 4'b0100,
      PH_RED    = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] red;
      logic [BYTE_WIDTH-1:0] green;
      logic [BYTE_WIDTH-1:0] blue;
      logic [BYTE_WIDTH-1:0] repeat_count;
      logic                  last_of_image;
   } beat_type;

   typedef struct packed {
      logic     push;
      beat_type beat;
   } push_type;

endpackage

`default_nettype wire

// File: hdl/rle_truecolor_image_decoder.sv
// Run-length decoder for 24-bit truecolor image packet data.
// The req channel takes one packet byte per beat: a header byte, then blue,
// green and red bytes. The rsp channel gives one beat per red byte: the
// pixel color, a repeat count (always 1 inside raw packets) and a flag on
// the beat that completes the configured width times height pixels; the
// byte after that flagged beat is taken as the first header of a new image.
// The csr port writes the row length in pixels (index 0) and the row count
// (index 1); other indexes are ignored. Write them only while no beat is in flight.
// Throughput is one byte per cycle while req_stall is low. A result passes
// through the queue and then the output register before rsp_valid shows it.
// After each register write req_stall stays high while the registered size
// product and remaining pixel count are refreshed.
// Reset sets both sizes to 1 and the parser to expect a header byte.
// A two-beat queue sits in front of the output register, so a stalled
// receiver holds the output while bytes keep flowing until the queue fills;
// then req_stall rises until the receiver takes a beat.
`default_nettype none

module rle_truecolor_image_decoder import rleid_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [BYTE_WIDTH-1:0]      req_packet_byte,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [BYTE_WIDTH-1:0]           rsp_red,
   output logic [BYTE_WIDTH-1:0]           rsp_green,
   output logic [BYTE_WIDTH-1:0]           rsp_blue,
   output logic [BYTE_WIDTH-1:0]           rsp_repeat_count,
   output logic                            rsp_last_of_image,
   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [SIZE_WIDTH-1:0]      csr_data
);

   push_type front_push;
   logic     queue_full;

   rleid_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_packet_byte (req_packet_byte),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .queue_full      (queue_full),
      .to_back         (front_push)
   );

   rleid_back u_back (
      .clock             (clock),
      .reset             (reset),
      .from_front        (front_push),
      .queue_full        (queue_full),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_repeat_count  (rsp_repeat_count),
      .rsp_last_of_image (rsp_last_of_image)
   );

endmodule

`default_nettype wire

// File: hdl/rleid_front.sv
`default_nettype none

module rleid_front import rleid_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [BYTE_WIDTH-1:0]      req_packet_byte,
   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [SIZE_WIDTH-1:0]      csr_data,
   input  wire logic                       queue_full,
   output push_type                        to_back
);

   logic [SIZE_WIDTH-1:0]   width_ff, height_ff;
   logic [PIXEL_WIDTH-1:0]  total_ff, remaining_ff, remaining_in;
   logic [SETTLE_WIDTH-1:0] settle_ff, settle_in;

   phase_type               phase_ff, phase_in;
   logic                    raw_ff, raw_in;
   logic [BYTE_WIDTH-1:0]   left_ff, left_in;
   logic [BYTE_WIDTH-1:0]   blue_ff, blue_in;
   logic [BYTE_WIDTH-1:0]   green_ff, green_in;
   logic [PIXEL_WIDTH-1:0]  emitted_ff, emitted_in;

   logic                    accept;
   logic [BYTE_WIDTH-1:0]   count_raw, count, left_dec;
   logic                    last_hit;

   assign req_stall = (settle_ff != '0) || queue_full;
   assign accept    = req_valid && !req_stall;

   // The remaining pixel count is kept one register ahead of the parser.
   // Red bytes are at least three beats apart, and register writes hold
   // the input off long enough for the size product to settle.
   always_comb begin
      if (csr_write) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
      if (emitted_ff < total_ff) begin
         remaining_in = total_ff - emitted_ff;
      end else begin
         remaining_in = PIXEL_WIDTH'(1);
      end
   end

   assign count_raw = raw_ff ? BYTE_WIDTH'(1) : left_ff;
   assign last_hit  = (remaining_ff[PIXEL_WIDTH-1:BYTE_WIDTH] == '0) &&
                      (count_raw >= remaining_ff[BYTE_WIDTH-1:0]);
   assign count     = last_hit ? remaining_ff[BYTE_WIDTH-1:0] : count_raw;
   assign left_dec  = left_ff - 1'b1;

   always_comb begin
      phase_in   = phase_ff;
      raw_in     = raw_ff;
      left_in    = left_ff;
      blue_in    = blue_ff;
      green_in   = green_ff;
      emitted_in = emitted_ff;
      to_back.push               = 1'b0;
      to_back.beat.red           = req_packet_byte;
      to_back.beat.green         = green_ff;
      to_back.beat.blue          = blue_ff;
      to_back.beat.repeat_count  = count;
      to_back.beat.last_of_image = last_hit;
      if (accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               raw_in   = !req_packet_byte[PKT_TYPE_BIT];
               left_in  = BYTE_WIDTH'(req_packet_byte[6:0] & PKT_COUNT_MASK) + 1'b1;
               phase_in = PH_BLUE;
            end
            PH_BLUE: begin
               blue_in  = req_packet_byte;
               phase_in = PH_GREEN;
            end
            PH_GREEN: begin
               green_in = req_packet_byte;
               phase_in = PH_RED;
            end
            PH_RED: begin
               to_back.push = 1'b1;
               emitted_in   = emitted_ff + PIXEL_WIDTH'(count);
               if (last_hit) begin
                  phase_in   = PH_HEADER;
                  raw_in     = 1'b0;
                  left_in    = '0;
                  emitted_in = '0;
               end else if (raw_ff) begin
                  left_in  = left_dec;
                  phase_in = (left_dec == '0) ? PH_HEADER : PH_BLUE;
               end else begin
                  left_in  = '0;
                  phase_in = PH_HEADER;
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SIZE_WIDTH'(1);
         height_ff    <= SIZE_WIDTH'(1);
         total_ff     <= PIXEL_WIDTH'(1);
         remaining_ff <= PIXEL_WIDTH'(1);
         settle_ff    <= '0;
         phase_ff     <= PH_HEADER;
         raw_ff       <= 1'b0;
         left_ff      <= '0;
         emitted_ff   <= '0;
      end else begin
         if (csr_write && (csr_index == CSR_ROW_LENGTH)) begin
            width_ff <= csr_data;
         end
         if (csr_write && (csr_index == CSR_ROW_COUNT)) begin
            height_ff <= csr_data;
         end
         total_ff     <= PIXEL_WIDTH'(width_ff) * PIXEL_WIDTH'(height_ff);
         remaining_ff <= remaining_in;
         settle_ff    <= settle_in;
         phase_ff     <= phase_in;
         raw_ff       <= raw_in;
         left_ff      <= left_in;
         emitted_ff   <= emitted_in;
      end
   end

   always_ff @(posedge clock) begin
      blue_ff  <= blue_in;
      green_ff <= green_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      to_back.push |-> (count != '0) && (count <= BYTE_WIDTH'(128)))
      else $error("repeat count out of range");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (to_back.push && to_back.beat.last_of_image) |=>
         (phase_ff == PH_HEADER) && (emitted_ff == '0))
      else $error("image end did not restart the parser");

   a_write_holds_input: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> req_stall)
      else $error("input taken while image size settles");

   a_red_only_pushes: assert property (@(posedge clock) disable iff (reset)
      to_back.push |=> (phase_ff == PH_HEADER) || (phase_ff == PH_BLUE))
      else $error("parser did not leave the red phase after a result");

endmodule

`default_nettype wire

// File: hdl/rleid_back.sv
`default_nettype none

module rleid_back import rleid_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire push_type              from_front,
   output logic                       queue_full,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [BYTE_WIDTH-1:0]      rsp_red,
   output logic [BYTE_WIDTH-1:0]      rsp_green,
   output logic [BYTE_WIDTH-1:0]      rsp_blue,
   output logic [BYTE_WIDTH-1:0]      rsp_repeat_count,
   output logic                       rsp_last_of_image
);

   beat_type                     queue_mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         valid_ff, valid_in;
   beat_type                     beat_ff;
   logic                         load;

   assign queue_full = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign load       = (count_ff != '0) && (!valid_ff || !rsp_stall);

   always_comb begin
      count_in = count_ff;
      if (from_front.push && !load) begin
         count_in = count_ff + 1'b1;
      end else if (!from_front.push && load) begin
         count_in = count_ff - 1'b1;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         if (from_front.push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (load) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (from_front.push) begin
         queue_mem[wr_ptr_ff] <= from_front.beat;
      end
      if (load) begin
         beat_ff <= queue_mem[rd_ptr_ff];
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_red           = beat_ff.red;
   assign rsp_green         = beat_ff.green;
   assign rsp_blue          = beat_ff.blue;
   assign rsp_repeat_count  = beat_ff.repeat_count;
   assign rsp_last_of_image = beat_ff.last_of_image;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      from_front.push |-> !queue_full)
      else $error("push into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_COUNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_output_fills: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && !valid_ff |=> valid_ff)
      else $error("waiting beat not moved to the output register");

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
   import rleid_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_B = 2'd3;
   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned PHASE_BYTES   = 85;
   localparam int unsigned DRAIN_LIMIT   = 20000;
   localparam int unsigned QUIET_CYCLES  = 8;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [BYTE_WIDTH-1:0]      req_packet_byte = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [BYTE_WIDTH-1:0]      rsp_red;
   logic [BYTE_WIDTH-1:0]      rsp_green;
   logic [BYTE_WIDTH-1:0]      rsp_blue;
   logic [BYTE_WIDTH-1:0]      rsp_repeat_count;
   logic                       rsp_last_of_image;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [SIZE_WIDTH-1:0]      csr_data = '0;

   rle_truecolor_image_decoder u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_packet_byte   (req_packet_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_repeat_count  (rsp_repeat_count),
      .rsp_last_of_image (rsp_last_of_image),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Decoder state mirrored by the testbench.
   logic [SIZE_WIDTH-1:0]  size_w = 16'd1;
   logic [SIZE_WIDTH-1:0]  size_h = 16'd1;
   phase_type              parse_state = PH_HEADER;
   logic                   raw_run = 1'b0;
   logic [BYTE_WIDTH-1:0]  run_left = '0;
   logic [BYTE_WIDTH-1:0]  blue_hold = '0;
   logic [BYTE_WIDTH-1:0]  green_hold = '0;
   logic [PIXEL_WIDTH-1:0] pixel_count = '0;

   logic [BYTE_WIDTH-1:0]  byte_q[$];
   beat_type               pixel_q[$];

   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned err_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned results_seen = 0;
   int unsigned images_done = 0;

   task automatic report_error(input string msg);
      $display("ERROR: %s", msg);
      err_count++;
   endtask

   function automatic void restart_image();
      parse_state = PH_HEADER;
      raw_run     = 1'b0;
      run_left    = '0;
      blue_hold   = '0;
      green_hold  = '0;
      pixel_count = '0;
   endfunction

   function automatic void decode_byte(input logic [BYTE_WIDTH-1:0] b);
      logic [63:0] total;
      logic [63:0] remain;
      logic [63:0] span;
      beat_type    beat;
      case (parse_state)
         PH_HEADER: begin
            raw_run     = !b[PKT_TYPE_BIT];
            run_left    = {1'b0, b[6:0] & PKT_COUNT_MASK} + 8'd1;
            parse_state = PH_BLUE;
         end
         PH_BLUE: begin
            blue_hold   = b;
            parse_state = PH_GREEN;
         end
         PH_GREEN: begin
            green_hold  = b;
            parse_state = PH_RED;
         end
         default: begin
            total  = 64'(size_w) * 64'(size_h);
            remain = (64'(pixel_count) < total) ? total - 64'(pixel_count) : 64'd1;
            span   = raw_run ? 64'd1 : 64'(run_left);
            if (span == 0) begin
               span = 64'd1;
            end
            if (span > remain) begin
               span = remain;
            end
            beat.red           = b;
            beat.green         = green_hold;
            beat.blue          = blue_hold;
            beat.repeat_count  = span[BYTE_WIDTH-1:0];
            pixel_count        = pixel_count + span[PIXEL_WIDTH-1:0];
            beat.last_of_image = 64'(pixel_count) >= total;
            pixel_q.push_back(beat);
            if (beat.last_of_image) begin
               restart_image();
            end else if (raw_run) begin
               run_left    = run_left - 8'd1;
               parse_state = (run_left == 0) ? PH_HEADER : PH_BLUE;
            end else begin
               run_left    = '0;
               parse_state = PH_HEADER;
            end
         end
      endcase
   endfunction

   // Byte driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_packet_byte);
            bytes_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               req_valid       <= 1'b1;
               req_packet_byte <= byte_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // Pixel monitor.
   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_q.size() == 0) begin
            report_error($sformatf("beat %0d arrived with nothing expected", results_seen));
         end else begin
            want = pixel_q.pop_front();
            if (rsp_red !== want.red)
               report_error($sformatf("beat %0d red %0h, expected %0h",
                  results_seen, rsp_red, want.red));
            if (rsp_green !== want.green)
               report_error($sformatf("beat %0d green %0h, expected %0h",
                  results_seen, rsp_green, want.green));
            if (rsp_blue !== want.blue)
               report_error($sformatf("beat %0d blue %0h, expected %0h",
                  results_seen, rsp_blue, want.blue));
            if (rsp_repeat_count !== want.repeat_count)
               report_error($sformatf("beat %0d repeat_count %0d, expected %0d",
                  results_seen, rsp_repeat_count, want.repeat_count));
            if (rsp_last_of_image !== want.last_of_image)
               report_error($sformatf("beat %0d last_of_image %0b, expected %0b",
                  results_seen, rsp_last_of_image, want.last_of_image));
         end
         results_seen++;
         if (rsp_last_of_image === 1'b1) begin
            images_done++;
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [SIZE_WIDTH-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      if (idx == CSR_ROW_LENGTH) begin
         size_w = val;
      end else if (idx == CSR_ROW_COUNT) begin
         size_h = val;
      end
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic write_size(input logic [SIZE_WIDTH-1:0] w, input logic [SIZE_WIDTH-1:0] h);
      write_reg(CSR_ROW_LENGTH, w);
      write_reg(CSR_ROW_COUNT, h);
   endtask

   task automatic queue_bytes(input logic [BYTE_WIDTH-1:0] seq[]);
      foreach (seq[i]) begin
         byte_q.push_back(seq[i]);
      end
   endtask

   // Waits until every byte is taken and every pixel has come back, then lets
   // the decoder finish any byte that produces no beat.
   task automatic wait_quiet();
      int unsigned guard;
      guard = 0;
      while ((byte_q.size() != 0 || req_valid || pixel_q.size() != 0) && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (pixel_q.size() != 0) begin
         report_error($sformatf("%0d expected beats never arrived", pixel_q.size()));
         pixel_q.delete();
      end
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random_phase(input int unsigned n);
      int unsigned added;
      int unsigned npix;
      logic [BYTE_WIDTH-1:0] hdr;
      added = 0;
      while (added < n) begin
         hdr = BYTE_WIDTH'($urandom_range(255));
         if ($urandom_range(7) != 0) begin
            hdr[6:0] = 7'($urandom_range(7));
         end
         byte_q.push_back(hdr);
         added++;
         npix = hdr[PKT_TYPE_BIT] ? 1 : hdr[6:0] + 1;
         // Now and then a packet is cut short or left without its colors.
         if ($urandom_range(9) == 0) begin
            npix = $urandom_range(npix);
         end
         // A long packet is cut at the byte budget of the phase.
         if (added + 3 * npix > n) begin
            npix = (n - added + 2) / 3;
         end
         repeat (3 * npix) begin
            byte_q.push_back(BYTE_WIDTH'($urandom_range(255)));
            added++;
         end
      end
   endtask

   function automatic logic [SIZE_WIDTH-1:0] pick_size(input bit allow_wide);
      if (allow_wide && $urandom_range(7) == 0) begin
         return SIZE_WIDTH'($urandom_range(65535));
      end
      return SIZE_WIDTH'($urandom_range(1, 6));
   endfunction

   initial begin
      req_idle_pct = 26;
      rsp_idle_pct = 65;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_reg(CSR_SPARE_A, 16'hFFFF);
      write_reg(CSR_SPARE_B, 16'h0000);
      write_size(16'd3, 16'd2);
      queue_bytes('{8'h00, 8'h00, 8'hFF, 8'h00,
                    8'h80, 8'hFF, 8'h00, 8'hFF,
                    8'hFF, 8'h12, 8'h34, 8'h56});
      wait_quiet();

      write_size(16'd0, 16'd5);
      queue_bytes('{8'h85, 8'h01, 8'h02, 8'h03});
      wait_quiet();

      write_size(16'hFFFF, 16'd0);
      queue_bytes('{8'h00, 8'hAA, 8'h55, 8'hC3});
      wait_quiet();

      // Widest image, then a raw packet is left open so the next, smaller size
      // is already exceeded when its first pixel arrives.
      write_reg(CSR_ROW_COUNT, 16'hFFFF);
      queue_bytes('{8'hFF, 8'h3C, 8'h96, 8'h69, 8'h7F, 8'h5A, 8'hA5, 8'h0F});
      wait_quiet();

      for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
         case (p / 2)
            0: begin
               req_idle_pct = 26;
               rsp_idle_pct = 65;
            end
            1: begin
               req_idle_pct = 65;
               rsp_idle_pct = 26;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         write_size(pick_size(p != 0), pick_size(p != 0));
         queue_random_phase(PHASE_BYTES);
         wait_quiet();
      end

      $display("Checked %0d pixel beats from %0d packet bytes, %0d images completed,",
               results_seen, bytes_sent, images_done);
      $display("across raw and repeat packets, clipped spans and zero and full-range sizes.");
      if (err_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
hdl/rleid_pkg.sv
hdl/rleid_front.sv
hdl/rleid_back.sv
hdl/rle_truecolor_image_decoder.sv
tb/testbench.sv
